// ===== rtl/core/svs_pkg.sv =====
// servo axis command supervisor: shared types, register indexes and constants
// no dependencies; used by servo_axis_command_supervisor
`timescale 1ns / 1ps
`default_nettype none

package svs_pkg;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_LIMIT       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_LIMIT       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HOME_OFFSET     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WORD_SHUTDOWN   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_WORD_SWITCH_ON  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_WORD_ENABLE     = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_WORD_PROFILE_GO = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_WORD_QUICK_STOP = 3'd7;

	// register reset values
	localparam logic [15:0] RST_WORD_SHUTDOWN   = 16'd6;
	localparam logic [15:0] RST_WORD_SWITCH_ON  = 16'd7;
	localparam logic [15:0] RST_WORD_ENABLE     = 16'd15;
	localparam logic [15:0] RST_WORD_PROFILE_GO = 16'd63;
	localparam logic [15:0] RST_WORD_QUICK_STOP = 16'd2;

	// fixed control word and status bits
	localparam logic [15:0] CW_FAULT_RESET = 16'h0080;
	localparam int unsigned SW_READY       = 0;
	localparam int unsigned SW_SWITCHED_ON = 1;
	localparam int unsigned SW_ENABLED     = 2;
	localparam int unsigned SW_FAULT       = 3;
	localparam int unsigned SW_ACK         = 12;

	// unsigned 32-bit divide by ten: (x * RECIP_TEN) >> RECIP_SHIFT
	localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int unsigned RECIP_SHIFT = 35;
	localparam int unsigned QUOT_W      = 64 - RECIP_SHIFT;

	// widened limits need one bit beyond 32
	localparam int unsigned WIDE_W = 33;

	typedef struct packed {
		logic        [15:0] status_word;
		logic signed [31:0] actual_position;
		logic signed [31:0] target_position;
		logic               profile_position_mode;
		logic               even_cycle;
		logic               homing_done;
	} item_t;

	typedef struct packed {
		logic        [15:0] control_word;
		logic               drive_operational;
		logic               target_valid;
		logic signed [31:0] target_out;
		logic               at_limit;
		logic               over_travel;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/servo_axis_command_supervisor.sv =====
// servo axis command supervisor: over-travel check, power ladder control word
// and clamped absolute target; depends on svs_pkg
// an accepted item is held in the input stage and then registered into the result register
// throughput: one item per cycle while result_ready holds; input stage and result register decouple the two sides
// widened limits are formed in a register at the configuration write (one multiply)
// arst_n clears the pipeline valid flags, the axis state and the registers to their reset values
`timescale 1ns / 1ps
`default_nettype none

module servo_axis_command_supervisor (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_we,
	input  wire logic [svs_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [svs_pkg::CFG_DATA_W-1:0]    cfg_data,
	// item channel
	input  wire logic                              item_valid,
	output logic                                   item_ready,
	input  wire svs_pkg::item_t                    item,
	// result channel
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output svs_pkg::result_t                       result
);

	// configuration registers
	logic signed [31:0] max_limit_q;
	logic signed [31:0] min_limit_q;
	logic signed [31:0] home_offset_q;
	logic [15:0]        word_shutdown_q;
	logic [15:0]        word_switch_on_q;
	logic [15:0]        word_enable_q;
	logic [15:0]        word_profile_go_q;
	logic [15:0]        word_quick_stop_q;
	logic signed [svs_pkg::WIDE_W-1:0] upper_q;
	logic signed [svs_pkg::WIDE_W-1:0] lower_q;

	// axis state
	logic               pending_q;
	logic               quick_stop_q;
	logic               limit_q;
	logic signed [31:0] last_target_q;

	// pipeline
	logic               valid_s1;
	svs_pkg::item_t     item_s1;
	logic               result_valid_q;
	svs_pkg::result_t   result_q;
	logic               advance;

	// widened limit from write data: value +/- |value|/10
	logic [31:0]                     cfg_abs;
	logic [63:0]                     cfg_prod;
	logic [svs_pkg::WIDE_W-1:0]      cfg_quot;
	logic signed [svs_pkg::WIDE_W-1:0] cfg_sext;
	logic signed [svs_pkg::WIDE_W-1:0] upper_new;
	logic signed [svs_pkg::WIDE_W-1:0] lower_new;

	always_comb begin
		cfg_abs   = cfg_data[31] ? (~cfg_data + 32'd1) : cfg_data;
		cfg_prod  = {32'd0, cfg_abs} * {32'd0, svs_pkg::RECIP_TEN};
		cfg_quot  = {{(svs_pkg::WIDE_W-svs_pkg::QUOT_W){1'b0}},
			cfg_prod[63:svs_pkg::RECIP_SHIFT]};
		cfg_sext  = {cfg_data[31], cfg_data};
		upper_new = cfg_data[31] ? (cfg_sext - cfg_quot) : (cfg_sext + cfg_quot);
		lower_new = cfg_sext - cfg_quot;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_limit_q       <= '0;
			min_limit_q       <= '0;
			home_offset_q     <= '0;
			word_shutdown_q   <= svs_pkg::RST_WORD_SHUTDOWN;
			word_switch_on_q  <= svs_pkg::RST_WORD_SWITCH_ON;
			word_enable_q     <= svs_pkg::RST_WORD_ENABLE;
			word_profile_go_q <= svs_pkg::RST_WORD_PROFILE_GO;
			word_quick_stop_q <= svs_pkg::RST_WORD_QUICK_STOP;
			upper_q           <= '0;
			lower_q           <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				svs_pkg::REG_MAX_LIMIT: begin
					max_limit_q <= cfg_data;
					upper_q     <= upper_new;
				end
				svs_pkg::REG_MIN_LIMIT: begin
					min_limit_q <= cfg_data;
					lower_q     <= lower_new;
				end
				svs_pkg::REG_HOME_OFFSET:     home_offset_q     <= cfg_data;
				svs_pkg::REG_WORD_SHUTDOWN:   word_shutdown_q   <= cfg_data[15:0];
				svs_pkg::REG_WORD_SWITCH_ON:  word_switch_on_q  <= cfg_data[15:0];
				svs_pkg::REG_WORD_ENABLE:     word_enable_q     <= cfg_data[15:0];
				svs_pkg::REG_WORD_PROFILE_GO: word_profile_go_q <= cfg_data[15:0];
				svs_pkg::REG_WORD_QUICK_STOP: word_quick_stop_q <= cfg_data[15:0];
			endcase
		end
	end

	// handshake: s1 moves on when the result register is free or being drained
	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// per-item logic on the input stage
	logic signed [31:0]                rel;
	logic signed [svs_pkg::WIDE_W-1:0] rel_x;
	logic                              over_hi;
	logic                              over_lo;
	logic                              qs_next;
	logic                              pend_armed;
	logic                              pend_next;
	logic [15:0]                       cw;
	logic                              oper;
	logic signed [31:0]                tgt_next;
	logic                              limit_next;

	always_comb begin
		// over-travel against widened limits
		rel     = item_s1.actual_position - home_offset_q;
		rel_x   = {rel[31], rel};
		over_hi = rel_x > upper_q;
		over_lo = !over_hi && (rel_x < lower_q);
		if (over_hi) begin
			qs_next = item_s1.target_position > max_limit_q;
		end else if (over_lo) begin
			qs_next = item_s1.target_position < min_limit_q;
		end else begin
			qs_next = quick_stop_q;
		end

		// go request armed on even cycles in profile mode
		pend_armed = pending_q || (item_s1.profile_position_mode && item_s1.even_cycle);
		pend_next  = pend_armed;

		// power ladder
		if (qs_next) begin
			cw   = word_quick_stop_q;
			oper = 1'b0;
		end else if (item_s1.status_word[svs_pkg::SW_ENABLED] ||
				item_s1.status_word[svs_pkg::SW_SWITCHED_ON]) begin
			if (pend_armed) begin
				cw = word_profile_go_q;
				if (item_s1.status_word[svs_pkg::SW_ACK]) begin
					pend_next = 1'b0;
				end
			end else begin
				cw = word_enable_q;
			end
			oper = 1'b1;
		end else if (item_s1.status_word[svs_pkg::SW_READY]) begin
			cw   = word_switch_on_q;
			oper = 1'b1;
		end else if (item_s1.status_word[svs_pkg::SW_FAULT]) begin
			cw   = svs_pkg::CW_FAULT_RESET;
			oper = 1'b0;
		end else begin
			cw   = word_shutdown_q;
			oper = 1'b0;
		end

		// absolute target, clamped once homed
		tgt_next   = last_target_q;
		limit_next = limit_q;
		if (oper) begin
			if (!item_s1.homing_done) begin
				tgt_next = home_offset_q;
			end else if (item_s1.target_position >= max_limit_q) begin
				tgt_next   = max_limit_q + home_offset_q;
				limit_next = 1'b1;
			end else if (item_s1.target_position <= min_limit_q) begin
				tgt_next   = min_limit_q + home_offset_q;
				limit_next = 1'b1;
			end else begin
				tgt_next   = item_s1.target_position + home_offset_q;
				limit_next = 1'b0;
			end
		end
	end

	// input stage, result register and axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			pending_q      <= 1'b0;
			quick_stop_q   <= 1'b0;
			limit_q        <= 1'b0;
			last_target_q  <= '0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
				pending_q      <= pend_next;
				quick_stop_q   <= qs_next;
				limit_q        <= limit_next;
				last_target_q  <= tgt_next;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_q.control_word      <= cw;
			result_q.drive_operational <= oper;
			result_q.target_valid      <= oper;
			result_q.target_out        <= tgt_next;
			result_q.at_limit          <= limit_next;
			result_q.over_travel       <= over_hi || over_lo;
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/servo_axis_command_supervisor_tb.sv =====
// testbench for servo_axis_command_supervisor: directed and random commands with a
// built-in predictor of the power ladder, over-travel check and target clamp
// depends on svs_pkg and servo_axis_command_supervisor
`timescale 1ns / 1ps

module servo_axis_command_supervisor_tb;

	localparam longint WIDEN_DIV = 10;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [svs_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [svs_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                            item_valid = 1'b0;
	logic                            item_ready;
	svs_pkg::item_t                  item = '0;
	logic                            result_valid;
	logic                            result_ready = 1'b0;
	svs_pkg::result_t                result;

	// predictor copy of the registers and the axis state
	int          lim_max, lim_min, home_pos;
	logic [15:0] shutdown_word, cw_switch_on, cw_enable, cw_go, cw_qstop;
	logic        go_pending, qstop_active, clamp_flag;
	logic [31:0] held_target;

	svs_pkg::result_t commands_due[$];
	int      mismatch_count = 0;
	bit      steady_run = 1'b0;
	int      ready_hold = 0;

	servo_axis_command_supervisor DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #10 clk = ~clk;

	// one control cycle of the axis: over-travel, control word, target
	function automatic svs_pkg::result_t next_command(input svs_pkg::item_t it);
		svs_pkg::result_t r;
		int          tgt, rel;
		longint      hi, lo, upper, lower, mag;
		logic [15:0] sw;
		logic        oper, over;
		sw = it.status_word;
		tgt = it.target_position;
		rel = it.actual_position - home_pos;
		hi = lim_max;
		lo = lim_min;
		mag = (lo < 0) ? -lo : lo;
		upper = hi + hi / WIDEN_DIV;
		lower = lo - mag / WIDEN_DIV;
		over = 1'b0;
		if (rel > upper) begin
			over = 1'b1;
			qstop_active = (tgt > hi);
		end else if (rel < lower) begin
			over = 1'b1;
			qstop_active = (tgt < lo);
		end
		if (it.profile_position_mode && it.even_cycle)
			go_pending = 1'b1;
		// power ladder
		if (qstop_active) begin
			r.control_word = cw_qstop;
			oper = 1'b0;
		end else if (sw[svs_pkg::SW_ENABLED] || sw[svs_pkg::SW_SWITCHED_ON]) begin
			if (go_pending) begin
				r.control_word = cw_go;
				if (sw[svs_pkg::SW_ACK])
					go_pending = 1'b0;
			end else begin
				r.control_word = cw_enable;
			end
			oper = 1'b1;
		end else if (sw[svs_pkg::SW_READY]) begin
			r.control_word = cw_switch_on;
			oper = 1'b1;
		end else if (sw[svs_pkg::SW_FAULT]) begin
			r.control_word = svs_pkg::CW_FAULT_RESET;
			oper = 1'b0;
		end else begin
			r.control_word = shutdown_word;
			oper = 1'b0;
		end
		// absolute target, clamped once homed
		if (oper) begin
			if (!it.homing_done) begin
				held_target = home_pos;
			end else if (tgt >= lim_max) begin
				held_target = lim_max + home_pos;
				clamp_flag = 1'b1;
			end else if (tgt <= lim_min) begin
				held_target = lim_min + home_pos;
				clamp_flag = 1'b1;
			end else begin
				held_target = tgt + home_pos;
				clamp_flag = 1'b0;
			end
		end
		r.drive_operational = oper;
		r.target_valid = oper;
		r.target_out = held_target;
		r.at_limit = clamp_flag;
		r.over_travel = over;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch on %s: expected %h, got %h", name, want, got);
		end
	endtask

	// track register writes, predict on each input transfer, check each result transfer
	always @(posedge clk) begin : watch_ports
		svs_pkg::result_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					svs_pkg::REG_MAX_LIMIT:       lim_max = cfg_data;
					svs_pkg::REG_MIN_LIMIT:       lim_min = cfg_data;
					svs_pkg::REG_HOME_OFFSET:     home_pos = cfg_data;
					svs_pkg::REG_WORD_SHUTDOWN:   shutdown_word = cfg_data[15:0];
					svs_pkg::REG_WORD_SWITCH_ON:  cw_switch_on = cfg_data[15:0];
					svs_pkg::REG_WORD_ENABLE:     cw_enable = cfg_data[15:0];
					svs_pkg::REG_WORD_PROFILE_GO: cw_go = cfg_data[15:0];
					svs_pkg::REG_WORD_QUICK_STOP: cw_qstop = cfg_data[15:0];
					default: ;
				endcase
			end
			if (item_valid && item_ready)
				commands_due.push_back(next_command(item));
			if (result_valid && result_ready) begin
				if (commands_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result transfer with nothing expected: %h", result);
				end else begin
					want = commands_due.pop_front();
					compare_field("control_word", want.control_word, result.control_word);
					compare_field("drive_operational", want.drive_operational,
						result.drive_operational);
					compare_field("target_valid", want.target_valid, result.target_valid);
					compare_field("target_out", want.target_out, result.target_out);
					compare_field("at_limit", want.at_limit, result.at_limit);
					compare_field("over_travel", want.over_travel, result.over_travel);
				end
			end
		end
	end

	// result side back-pressure in random bursts
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
			result_ready <= 1'b0;
		end else if (!steady_run && $urandom_range(0, 5) == 0) begin
			ready_hold <= $urandom_range(0, 10);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// one input transfer, with an occasional idle burst ahead of it
	task automatic send_item(input svs_pkg::item_t it);
		if (!steady_run && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(negedge clk); while (!item_ready);
		@(posedge clk);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (commands_due.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [svs_pkg::CFG_INDEX_W-1:0] idx,
			input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic load_setup(input int max_l, input int min_l, input int home,
			input logic [15:0] sd, input logic [15:0] so, input logic [15:0] en,
			input logic [15:0] go, input logic [15:0] qs);
		write_reg(svs_pkg::REG_MAX_LIMIT, max_l);
		write_reg(svs_pkg::REG_MIN_LIMIT, min_l);
		write_reg(svs_pkg::REG_HOME_OFFSET, home);
		write_reg(svs_pkg::REG_WORD_SHUTDOWN, {16'($urandom_range(0, 65535)), sd});
		write_reg(svs_pkg::REG_WORD_SWITCH_ON, {16'h0, so});
		write_reg(svs_pkg::REG_WORD_ENABLE, {16'hffff, en});
		write_reg(svs_pkg::REG_WORD_PROFILE_GO, {16'h0, go});
		write_reg(svs_pkg::REG_WORD_QUICK_STOP, {16'h0, qs});
		cfg_we <= 1'b0;
		// widened limits settle after the write
		repeat (4) @(posedge clk);
	endtask

	function automatic svs_pkg::item_t make_item(input logic [15:0] sw, input int act,
			input int tgt, input logic ppm, input logic even, input logic homed);
		svs_pkg::item_t it;
		it.status_word = sw;
		it.actual_position = act;
		it.target_position = tgt;
		it.profile_position_mode = ppm;
		it.even_cycle = even;
		it.homing_done = homed;
		return it;
	endfunction

	// positions cluster around the limits and the widened limits
	function automatic svs_pkg::item_t random_item();
		svs_pkg::item_t it;
		longint      hi, lo, upper, lower, rel, tgt;
		logic [15:0] sw;
		hi = lim_max;
		lo = lim_min;
		upper = hi + hi / WIDEN_DIV;
		lower = lo - ((lo < 0) ? -lo : lo) / WIDEN_DIV;
		case ($urandom_range(0, 5))
			0: rel = upper + int'($urandom_range(0, 4)) - 2;
			1: rel = lower + int'($urandom_range(0, 4)) - 2;
			2: rel = hi + int'($urandom_range(0, 4)) - 2;
			3: rel = lo + int'($urandom_range(0, 4)) - 2;
			4: rel = (hi >= lo) ? lo + longint'($urandom) % (hi - lo + 1) : 0;
			default: rel = int'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0: tgt = hi + int'($urandom_range(0, 2)) - 1;
			1: tgt = lo + int'($urandom_range(0, 2)) - 1;
			2, 3: tgt = (hi >= lo) ? lo + longint'($urandom) % (hi - lo + 1) : 0;
			4: tgt = int'($urandom);
			default: tgt = 0;
		endcase
		sw = 16'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: sw[svs_pkg::SW_ENABLED] = 1'b1;
			4: begin
				sw[svs_pkg::SW_ENABLED] = 1'b0;
				sw[svs_pkg::SW_SWITCHED_ON] = 1'b1;
			end
			5, 6: begin
				sw[svs_pkg::SW_ENABLED] = 1'b0;
				sw[svs_pkg::SW_SWITCHED_ON] = 1'b0;
				sw[svs_pkg::SW_READY] = 1'b1;
			end
			7: begin
				sw[3:0] = 4'b0000;
				sw[svs_pkg::SW_FAULT] = 1'b1;
			end
			8: sw[3:0] = 4'b0000;
			default: ;
		endcase
		it.status_word = sw;
		it.actual_position = rel[31:0] + home_pos;
		it.target_position = tgt[31:0];
		it.profile_position_mode = 1'($urandom_range(0, 1));
		it.even_cycle = 1'($urandom_range(0, 1));
		it.homing_done = ($urandom_range(0, 4) != 0);
		return it;
	endfunction

	function automatic logic [15:0] random_word();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// register reset values: zero limits and home, default words
	task automatic test_reset_defaults();
		send_item(make_item(16'h0000, 0, 0, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0001, 0, 5, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0004, 1, -1, 1'b1, 1'b1, 1'b1));
		send_item(make_item(16'h1004, -1, 0, 1'b0, 1'b0, 1'b0));
		wait_drained();
	endtask

	// each rung of the power ladder, homing, clamping and the set point handshake
	task automatic test_power_ladder();
		load_setup(1005, -1009, 5000, 16'h0006, 16'h0007, 16'h000f, 16'h003f, 16'h0002);
		send_item(make_item(16'h0000, 5000, 0, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0008, 5000, 0, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0001, 5000, 300, 1'b0, 1'b0, 1'b0));
		send_item(make_item(16'h0002, 5000, 500, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0004, 5000, 1005, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0004, 5000, -1009, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0004, 5000, 32'h7fffffff, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0004, 5000, 32'h80000000, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0006, 5000, 1004, 1'b1, 1'b0, 1'b1));
		send_item(make_item(16'h0004, 5000, -1008, 1'b1, 1'b1, 1'b1));
		send_item(make_item(16'h0002, 5000, 7, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h1004, 5000, 7, 1'b0, 1'b1, 1'b1));
		send_item(make_item(16'h0004, 5000, 7, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'hffff, 5000, 8, 1'b1, 1'b1, 1'b1));
		send_item(make_item(16'hfff0, 5000, 9, 1'b1, 1'b1, 1'b0));
		wait_drained();
	endtask

	// widened limits 1105 / -1109 around home, quick stop set, held and released
	task automatic test_over_travel();
		load_setup(1005, -1009, 5000, 16'h0106, 16'h0107, 16'h010f, 16'h013f, 16'h0102);
		send_item(make_item(16'h0004, 5000 + 1105, 2000, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0004, 5000 + 1106, 2000, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0004, 5000, 0, 1'b1, 1'b1, 1'b1));
		send_item(make_item(16'h0004, 5000 + 1106, 1005, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0004, 5000 - 1109, -2000, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0004, 5000 - 1110, -2000, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h1004, 5000 - 1110, -1009, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0004, 32'h7fffffff, 0, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0004, 32'h80000000, 0, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0001, 5000, 0, 1'b0, 1'b0, 1'b1));
		wait_drained();
	endtask

	// full range limits: widened limits leave 32 bits, sums wrap
	task automatic test_limit_extremes();
		load_setup(32'h7fffffff, 32'h80000000, 32'h7fffffff,
			16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff);
		send_item(make_item(16'h0004, 32'h80000000, 32'h7fffffff, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0004, 32'h7fffffff, 32'h80000000, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0004, 32'hfffffffe, 5, 1'b1, 1'b1, 1'b1));
		send_item(make_item(16'h0000, 0, 0, 1'b0, 1'b0, 1'b1));
		wait_drained();
		load_setup(32'h80000000, 32'h7fffffff, 32'h80000000,
			16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'h0000);
		send_item(make_item(16'h0004, 0, 0, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0004, 32'h80000000, 32'h80000000, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0001, 32'h7fffffff, 32'h7fffffff, 1'b0, 1'b0, 1'b1));
		wait_drained();
	endtask

	// minimum above maximum: upper checks win
	task automatic test_inverted_limits();
		load_setup(-100, 100, -50, 16'h0006, 16'h0007, 16'h000f, 16'h003f, 16'h0002);
		send_item(make_item(16'h0004, -50, 0, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0004, 0, 200, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0004, -200, -200, 1'b0, 1'b0, 1'b1));
		send_item(make_item(16'h0004, 100, 0, 1'b0, 1'b0, 1'b1));
		wait_drained();
	endtask

	// random register settings, each followed by random commands near the limits
	task automatic test_random_traffic(input int phases, input int per_phase);
		int mx, mn;
		for (int p = 0; p < phases; p++) begin
			case ($urandom_range(0, 3))
				0: begin
					mx = $urandom_range(0, 200000);
					mn = -int'($urandom_range(0, 200000));
				end
				1: begin
					mx = $urandom;
					mn = $urandom;
				end
				2: begin
					mx = $urandom_range(0, 30);
					mn = -int'($urandom_range(0, 30));
				end
				default: begin
					mx = ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
					mn = ($urandom_range(0, 1) != 0) ? 32'h80000000 : 32'h7fffffff;
				end
			endcase
			load_setup(mx, mn, $urandom, random_word(), random_word(), random_word(),
				random_word(), random_word());
			for (int i = 0; i < per_phase; i++)
				send_item(random_item());
			wait_drained();
		end
	endtask

	// back-to-back transfers with both sides always ready
	task automatic test_steady_stream(input int count);
		steady_run = 1'b1;
		load_setup(50000, -40000, $urandom, 16'h0006, 16'h0007, 16'h000f, 16'h003f, 16'h0002);
		for (int i = 0; i < count; i++)
			send_item(random_item());
		wait_drained();
	endtask

	initial begin
		lim_max = 0;
		lim_min = 0;
		home_pos = 0;
		shutdown_word = svs_pkg::RST_WORD_SHUTDOWN;
		cw_switch_on = svs_pkg::RST_WORD_SWITCH_ON;
		cw_enable = svs_pkg::RST_WORD_ENABLE;
		cw_go = svs_pkg::RST_WORD_PROFILE_GO;
		cw_qstop = svs_pkg::RST_WORD_QUICK_STOP;
		go_pending = 1'b0;
		qstop_active = 1'b0;
		clamp_flag = 1'b0;
		held_target = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_power_ladder();
		test_over_travel();
		test_limit_extremes();
		test_inverted_limits();
		test_random_traffic(8, 130);
		test_steady_stream(160);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && commands_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// overall time limit
	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/svs_pkg.sv
rtl/core/servo_axis_command_supervisor.sv
tb/sv/servo_axis_command_supervisor_tb.sv
